[src/fprc_pkg.sv]
// ----------------------------------------------------------------------------
// fprc_pkg - shared types and constants
// Payload structs, run widths and register indexes for the finder pattern
// run ratio check.
// ----------------------------------------------------------------------------
package fprc_pkg;

	// Line bound: run counters saturate here
	localparam int unsigned MAX_LINE_PIXELS = 4096;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned RUN_W      = 13;
	localparam int unsigned MIN_PCT_W  = 9;
	localparam int unsigned MAX_PCT_W  = 10;
	localparam int unsigned CFG_DATA_W = 10;
	localparam int unsigned CFG_IDX_W  = 2;

	// 3 * run / max_run scaled by 100 percent
	localparam int unsigned RATIO_SCALE = 300;
	localparam int unsigned PROD_W      = RUN_W + MAX_PCT_W;

	localparam logic [MIN_PCT_W-1:0] MIN_PCT_RESET = MIN_PCT_W'(40);
	localparam logic [MAX_PCT_W-1:0] MAX_PCT_RESET = MAX_PCT_W'(225);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = CFG_IDX_W'(1);

	typedef logic [RUN_W-1:0] run_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             line_end;
	} pix_t;

	typedef struct packed {
		logic line_pass;
		run_t longest_run;
	} res_t;

	// End-of-line summary handed from the run tracker to the ratio check
	typedef struct packed {
		run_t       max_run;
		run_t [1:0] prior;       // [0] farther, [1] adjacent
		run_t [1:0] after;       // arrival order
		logic       before_full; // two runs precede the longest
		logic       after_full;  // two runs follow the longest
	} snap_t;

endpackage

[src/fprc_run_tracker.sv]
// ----------------------------------------------------------------------------
// fprc_run_tracker - run length and longest-run neighbor tracking
// Holds the per-line state; produces the end-of-line summary on line_end.
// ----------------------------------------------------------------------------
module fprc_run_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           color,
	input  logic           last,
	output fprc_pkg::snap_t snap
);
	import fprc_pkg::*;

	localparam logic [1:0] CNT_FULL = 2'd2;

	typedef struct packed {
		run_t [1:0] recent;     // [0] older, [1] newer
		logic [1:0] seen;
		run_t       max_run;
		run_t [1:0] prior;
		logic [1:0] before_cnt;
		run_t [1:0] after;
		logic [1:0] after_cnt;
	} trk_t;

	logic line_start_q;
	logic prev_color_q;
	run_t cur_run_q;
	trk_t trk_q;

	trk_t trk_a;
	trk_t trk_b;
	run_t cur_a;
	logic chg;

	function automatic trk_t close_run(trk_t s, run_t r);
		trk_t n;
		n = s;
		if (r > s.max_run) begin
			n.max_run    = r;
			n.prior      = s.recent;
			n.before_cnt = s.seen;
			n.after      = '0;
			n.after_cnt  = '0;
		end else if (s.after_cnt < CNT_FULL) begin
			n.after[s.after_cnt[0]] = r;
			n.after_cnt             = s.after_cnt + 2'd1;
		end
		n.recent[0] = s.recent[1];
		n.recent[1] = r;
		if (s.seen < CNT_FULL) begin
			n.seen = s.seen + 2'd1;
		end
		return n;
	endfunction

	// Run update for this pixel, then the final close on line_end
	always_comb begin
		chg = !line_start_q && (color != prev_color_q);
		trk_a = chg ? close_run(trk_q, cur_run_q) : trk_q;
		if (line_start_q || chg) begin
			cur_a = RUN_W'(1);
		end else if (cur_run_q < RUN_W'(MAX_LINE_PIXELS)) begin
			cur_a = cur_run_q + RUN_W'(1);
		end else begin
			cur_a = cur_run_q;
		end
		trk_b = close_run(trk_a, cur_a);

		snap.max_run     = trk_b.max_run;
		snap.prior       = trk_b.prior;
		snap.after       = trk_b.after;
		snap.before_full = (trk_b.before_cnt == CNT_FULL);
		snap.after_full  = (trk_b.after_cnt == CNT_FULL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_start_q <= 1'b1;
			prev_color_q <= 1'b0;
			cur_run_q    <= '0;
			trk_q        <= '0;
		end else if (step) begin
			if (last) begin
				line_start_q <= 1'b1;
				prev_color_q <= 1'b0;
				cur_run_q    <= '0;
				trk_q        <= '0;
			end else begin
				line_start_q <= 1'b0;
				prev_color_q <= color;
				cur_run_q    <= cur_a;
				trk_q        <= trk_a;
			end
		end
	end

endmodule

[src/fprc_ratio_check.sv]
// ----------------------------------------------------------------------------
// fprc_ratio_check - neighbor run ratio test
// Registers the cross-products, then compares them against the bounds.
// ----------------------------------------------------------------------------
module fprc_ratio_check (
	input  logic                            clk,
	input  logic                            load,
	input  fprc_pkg::snap_t                 snap,
	input  logic [fprc_pkg::MIN_PCT_W-1:0]  min_pct,
	input  logic [fprc_pkg::MAX_PCT_W-1:0]  max_pct,
	output fprc_pkg::res_t                  res
);
	import fprc_pkg::*;

	logic [PROD_W-1:0]      lo_s3;
	logic [PROD_W-1:0]      hi_s3;
	logic [3:0][PROD_W-1:0] scaled_s3;
	run_t                   longest_s3;
	logic                   full_s3;

	run_t [3:0] nbr;
	logic [3:0] ok;

	assign nbr = {snap.after, snap.prior};

	always_ff @(posedge clk) begin
		if (load) begin
			lo_s3 <= PROD_W'(min_pct) * PROD_W'(snap.max_run);
			hi_s3 <= PROD_W'(max_pct) * PROD_W'(snap.max_run);
			for (int i = 0; i < 4; i++) begin
				scaled_s3[i] <= PROD_W'(nbr[i]) * PROD_W'(RATIO_SCALE);
			end
			longest_s3 <= snap.max_run;
			full_s3    <= snap.before_full && snap.after_full;
		end
	end

	// Both bounds exclusive
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ok[i] = (lo_s3 < scaled_s3[i]) && (scaled_s3[i] < hi_s3);
		end
		res.line_pass   = full_s3 && (&ok);
		res.longest_run = longest_s3;
	end

endmodule

[src/finder_pattern_run_ratio_check.sv]
// ----------------------------------------------------------------------------
// finder_pattern_run_ratio_check - 1:1:3:1:1 run pattern test on a scan line
// Measures black/white runs of one line and checks the neighbors of the
// first longest run against configurable ratio bounds.
// ----------------------------------------------------------------------------
// Usage
//  - pix channel: one pixel item per accepted beat; nonzero is white, zero is
//    black. line_end marks the last pixel of the line.
//  - res channel: one item per line, on its line_end pixel: line_pass and the
//    length of the first longest run. Pixels without line_end give nothing.
//  - cfg port: cfg_we writes cfg_data into register cfg_idx (0 min ratio,
//    1 max ratio, percent, exclusive). Other indexes are ignored. Write only
//    while no line result is outstanding.
//  - Throughput: one pixel per clock when not stalled; one compare/increment
//    plus at most two run closes form the run update in the tracker stage.
//  - Result path: a line_end pixel passes the input reg, summary reg,
//    product reg and result reg in turn, then res_valid rises.
//  - Stall: a held result keeps the pipeline's end full; pixels keep flowing
//    until a line_end pixel reaches the tracker with the summary and product
//    stages both occupied (three line results waiting), then pix_ready drops.
//  - Reset: line state cleared, ratio registers back to 40 and 225 percent,
//    no result pending.
// ----------------------------------------------------------------------------
module finder_pattern_run_ratio_check (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  fprc_pkg::pix_t                   pix,
	output logic                             res_valid,
	input  logic                             res_ready,
	output fprc_pkg::res_t                   res,
	input  logic                             cfg_we,
	input  logic [fprc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fprc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fprc_pkg::*;

	// Ratio bound registers
	logic [MIN_PCT_W-1:0] min_pct_q;
	logic [MAX_PCT_W-1:0] max_pct_q;

	// Stage 1: registered pixel
	logic v_s1;
	logic color_s1;
	logic last_s1;

	// Stage 2: end-of-line summary
	logic  v_s2;
	snap_t snap_s2;
	snap_t snap_nxt;

	// Stage 3: products (held inside the ratio check)
	logic v_s3;

	// Result register
	logic res_valid_q;
	res_t res_q;
	res_t res_nxt;

	// Backward ready chain; a stage is free when empty or draining
	logic rdy_out;
	logic rdy_s3;
	logic rdy_s2;
	logic rdy_s1;
	logic step;

	assign rdy_out = !res_valid_q || res_ready;
	assign rdy_s3  = !v_s3 || rdy_out;
	assign rdy_s2  = !v_s2 || rdy_s3;
	// Only a line_end pixel needs room downstream
	assign rdy_s1  = !v_s1 || !last_s1 || rdy_s2;
	assign step    = v_s1 && rdy_s1;

	assign pix_ready = rdy_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pct_q <= MIN_PCT_RESET;
			max_pct_q <= MAX_PCT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MIN_RATIO: min_pct_q <= cfg_data[MIN_PCT_W-1:0];
				REG_MAX_RATIO: max_pct_q <= cfg_data[MAX_PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix_valid) begin
			color_s1 <= (pix.pixel != '0);
			last_s1  <= pix.line_end;
		end
	end

	fprc_run_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.color  (color_s1),
		.last   (last_s1),
		.snap   (snap_nxt)
	);

	// Summary register: loaded only by a line_end pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= step && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && step && last_s1) begin
			snap_s2 <= snap_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	fprc_ratio_check u_ratio (
		.clk     (clk),
		.load    (rdy_s3 && v_s2),
		.snap    (snap_s2),
		.min_pct (min_pct_q),
		.max_pct (max_pct_q),
		.res     (res_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rdy_out) begin
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_s3) begin
			res_q <= res_nxt;
		end
	end

endmodule

[src/fprc_checker.sv]
// ----------------------------------------------------------------------------
// fprc_checker - port-level checks for the run ratio block
// Watches the pixel and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module fprc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pix_valid,
	input logic           pix_ready,
	input logic           res_valid,
	input logic           res_ready,
	input fprc_pkg::res_t res
);
	import fprc_pkg::*;

	// Stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// A line always has at least one run, never longer than the bound
	a_longest_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.longest_run != '0) &&
			(res.longest_run <= RUN_W'(MAX_LINE_PIXELS)))
		else $error("longest run out of range");

	// A pass needs the longest strictly above two shorter runs before it
	a_pass_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.line_pass |-> res.longest_run >= RUN_W'(2))
		else $error("pass with a longest run below two");

	// No result can appear unless something entered in the last cycles
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && !(pix_valid && pix_ready) ##1
		!res_valid && !(pix_valid && pix_ready) ##1
		!res_valid && !(pix_valid && pix_ready) ##1
		!res_valid && !(pix_valid && pix_ready) |=> !res_valid)
		else $error("result without an input item");

endmodule

bind finder_pattern_run_ratio_check fprc_checker u_fprc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

[bench/fprc_checker.sv]
// ----------------------------------------------------------------------------
// fprc_scoreboard - line result predictor and scoreboard
// Watches the pixel, result and register ports of the run ratio check, keeps
// its own run tracker and bound registers, and compares every result item
// against the oldest predicted line result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fprc_scoreboard (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	input  logic                             pix_ready,
	input  fprc_pkg::pix_t                   pix,
	input  logic                             res_valid,
	input  logic                             res_ready,
	input  fprc_pkg::res_t                   res,
	input  logic                             cfg_we,
	input  logic [fprc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [fprc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                      mismatches,
	output int unsigned                      outstanding
);
	import fprc_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	// bound registers, percent
	logic [MIN_PCT_W-1:0] lower_pct;
	logic [MAX_PCT_W-1:0] upper_pct;

	// run tracker
	logic       fresh_line;
	logic       color_prev;
	run_t       run_len;
	run_t       last_two [2];   // [0] older, [1] newer
	logic [1:0] last_two_cnt;
	run_t       longest;
	run_t       lead [2];       // [0] farther, [1] adjacent to longest
	logic [1:0] lead_cnt;
	run_t       follow [2];     // first two runs after longest
	logic [1:0] follow_cnt;

	res_t        line_results_q [$];
	int unsigned fail_cnt;

	function automatic void clear_line_state();
		fresh_line   = 1'b1;
		color_prev   = 1'b0;
		run_len      = '0;
		last_two[0]  = '0;
		last_two[1]  = '0;
		last_two_cnt = '0;
		longest      = '0;
		lead[0]      = '0;
		lead[1]      = '0;
		lead_cnt     = '0;
		follow[0]    = '0;
		follow[1]    = '0;
		follow_cnt   = '0;
	endfunction

	function automatic void close_run(run_t len);
		if (len > longest) begin
			// strictly longer only: ties keep the first longest
			longest    = len;
			lead[0]    = last_two[0];
			lead[1]    = last_two[1];
			lead_cnt   = last_two_cnt;
			follow[0]  = '0;
			follow[1]  = '0;
			follow_cnt = '0;
		end else if (follow_cnt < 2) begin
			follow[follow_cnt[0]] = len;
			follow_cnt++;
		end
		last_two[0] = last_two[1];
		last_two[1] = len;
		if (last_two_cnt < 2)
			last_two_cnt++;
	endfunction

	// min/100 < 3*len/longest < max/100, as cross-products
	function automatic bit ratio_in_range(run_t len);
		longint unsigned scaled, lo, hi;
		scaled = len * 64'(RATIO_SCALE);
		lo     = lower_pct * 64'(longest);
		hi     = upper_pct * 64'(longest);
		return (lo < scaled) && (scaled < hi);
	endfunction

	function automatic void take_pixel(pix_t p);
		logic white;
		res_t verdict;
		white = (p.pixel != '0);
		if (fresh_line) begin
			fresh_line = 1'b0;
			color_prev = white;
			run_len    = RUN_W'(1);
		end else if (white != color_prev) begin
			close_run(run_len);
			color_prev = white;
			run_len    = RUN_W'(1);
		end else if (run_len < MAX_LINE_PIXELS) begin
			run_len++;
		end
		if (p.line_end) begin
			close_run(run_len);
			verdict.line_pass = (lead_cnt >= 2) && (follow_cnt >= 2) &&
				ratio_in_range(lead[0]) && ratio_in_range(lead[1]) &&
				ratio_in_range(follow[0]) && ratio_in_range(follow[1]);
			verdict.longest_run = longest;
			line_results_q.insert(line_results_q.size(), verdict);
			clear_line_state();
		end
	endfunction

	function automatic void check_result(res_t got);
		res_t want;
		if (line_results_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= REPORT_LIMIT)
				$display("%0t: result pass=%0b run=%0d with no line pending",
					$realtime, got.line_pass, got.longest_run);
			return;
		end
		want = line_results_q.pop_front();
		if (got.line_pass !== want.line_pass ||
				got.longest_run !== want.longest_run) begin
			fail_cnt++;
			if (fail_cnt <= REPORT_LIMIT)
				$display("%0t: mismatch: expected pass=%0b run=%0d, got pass=%0b run=%0d",
					$realtime, want.line_pass, want.longest_run,
					got.line_pass, got.longest_run);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_pct = MIN_PCT_RESET;
			upper_pct = MAX_PCT_RESET;
			clear_line_state();
			line_results_q.delete();
			fail_cnt = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_MIN_RATIO)
					lower_pct = cfg_data[MIN_PCT_W-1:0];
				else if (cfg_idx == REG_MAX_RATIO)
					upper_pct = cfg_data[MAX_PCT_W-1:0];
			end
			if (pix_valid && pix_ready)
				take_pixel(pix);
			if (res_valid && res_ready)
				check_result(res);
			mismatches  <= fail_cnt;
			outstanding <= line_results_q.size();
		end
	end

endmodule

[bench/finder_pattern_run_ratio_check_test.sv]
// ----------------------------------------------------------------------------
// finder_pattern_run_ratio_check_test - top of the run ratio check bench
// Drives scan lines into the block (directed corner lines, then mostly
// 1:1:3:1:1 lines with jitter mixed with noise lines) across a series of
// bound settings, with bursty input and a stalling result sink.
// Prediction and comparison live in fprc_scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module finder_pattern_run_ratio_check_test;
	import fprc_pkg::*;

	localparam int unsigned RANDOM_ITEMS  = 1400;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 150;     // long sink hold-off
	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned FIXED_PHASES  = 6;

	// register indexes past the list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SPARSE} sink_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_ready;
	pix_t                  pix       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_t                  res;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned items_sent  = 0;
	int unsigned burst_left  = 0;
	bit          steady      = 1'b0;   // sender offers back to back
	bit          hold_request = 1'b0;  // asks the sink for a long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	finder_pattern_run_ratio_check uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data)
	);

	fprc_scoreboard u_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.pix         (pix),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result sink. The stall pattern is drawn anew at random intervals; a hold
	// request from the sender keeps it off long enough that the pipeline fills
	// and pix_ready has to drop.
	initial begin : result_sink
		sink_mode_e  mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned tick;
		mode      = SINK_OPEN;
		mode_left = 0;
		hold_left = 0;
		tick      = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = sink_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				case (mode)
				SINK_OPEN:     res_ready <= 1'b1;
				SINK_COIN:     res_ready <= 1'($urandom_range(0, 1));
				SINK_PERIODIC: res_ready <= (tick % 5) != 0;
				default:       res_ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	// Offer one pixel item and wait for it to be taken. Bursts of random
	// length with random gaps in front; gaps land anywhere inside a line.
	task automatic emit_pixel(input logic [PIX_W-1:0] value, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			if (gap > 0) begin
				pix_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_valid <= 1'b1;
		pix       <= {value, last};
		do @(posedge clk); while (!pix_ready);
		items_sent++;
	endtask

	// white pixels take any nonzero shade
	function automatic logic [PIX_W-1:0] shade(input bit white);
		return white ? PIX_W'($urandom_range(1, 255)) : '0;
	endfunction

	// Send a line as a list of run lengths with alternating colors.
	task automatic send_runs(input int unsigned lens[$], input bit white_first);
		bit white;
		white = white_first;
		foreach (lens[i]) begin
			for (int unsigned k = 0; k < lens[i]; k++)
				emit_pixel(shade(white), (i == lens.size() - 1) && (k == lens[i] - 1));
			white = !white;
		end
	endtask

	function automatic int unsigned near(input int unsigned unit);
		return $urandom_range((unit + 1) / 2, unit + (unit + 1) / 2);
	endfunction

	// Finder-like line: optional quiet runs, then 1:1:3:1:1 with jitter,
	// then optional trailing runs. A broken one loses its tail or has one
	// run made three times as long.
	task automatic send_pattern_line(input bit broken, input bit tiny);
		int unsigned lens[$];
		int unsigned unit;
		unit = tiny ? 1 : (($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
			: $urandom_range(1, 4));
		repeat ($urandom_range(0, 2)) lens.insert(lens.size(), $urandom_range(1, unit + 1));
		lens.insert(lens.size(), near(unit));
		lens.insert(lens.size(), near(unit));
		lens.insert(lens.size(), $urandom_range(2 * unit + 1, 4 * unit));
		lens.insert(lens.size(), near(unit));
		lens.insert(lens.size(), near(unit));
		repeat ($urandom_range(0, 2)) lens.insert(lens.size(), $urandom_range(1, unit + 1));
		if (broken) begin
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, lens.size() - 1)) void'(lens.pop_back());
			else
				lens[$urandom_range(0, lens.size() - 1)] *= 3;
		end
		send_runs(lens, $urandom_range(0, 1));
	endtask

	// Raw pixels: any value, zero weighted up so black pixels are common.
	task automatic send_noise_line(input int unsigned max_len);
		int unsigned len;
		len = $urandom_range(1, max_len);
		for (int unsigned k = 0; k < len; k++)
			emit_pixel(($urandom_range(0, 3) == 0) ? '0 : PIX_W'($urandom_range(0, 255)),
				k == len - 1);
	endtask

	task automatic send_random_line();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			send_pattern_line(1'b0, 1'b0);
		else if (pick < 7)
			send_pattern_line(1'b1, 1'b0);
		else
			send_noise_line(30);
	endtask

	// Drop valid, wait for every pending line result, let the pipe drain.
	task automatic wait_idle();
		pix_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Fixed phases walk the extremes (zero bounds, all-ones data with the
	// min register masking bit 9, inverted bounds); later phases are random.
	task automatic set_bounds(input int unsigned phase);
		case (phase)
		0: begin
			write_reg(REG_MIN_RATIO, CFG_DATA_W'(1));
			write_reg(REG_MAX_RATIO, CFG_DATA_W'(600));
		end
		1: begin
			write_reg(REG_MIN_RATIO, '0);
			write_reg(REG_MAX_RATIO, '1);
		end
		2: begin
			write_reg(REG_MIN_RATIO, '1);
			write_reg(REG_MAX_RATIO, '0);
		end
		3: begin
			write_reg(REG_MIN_RATIO, CFG_DATA_W'(300));
			write_reg(REG_MAX_RATIO, CFG_DATA_W'(1));
		end
		4: begin
			write_reg(REG_SPARE_A, '1);
			write_reg(REG_MIN_RATIO, CFG_DATA_W'(MIN_PCT_RESET));
			write_reg(REG_MAX_RATIO, CFG_DATA_W'(MAX_PCT_RESET));
			write_reg(REG_SPARE_B, '1);
		end
		5: begin
			write_reg(REG_MIN_RATIO, CFG_DATA_W'(80));
			write_reg(REG_MAX_RATIO, CFG_DATA_W'(130));
		end
		default: begin
			if ($urandom_range(0, 2) != 0) begin
				write_reg(REG_MIN_RATIO, CFG_DATA_W'($urandom_range(20, 100)));
				write_reg(REG_MAX_RATIO, CFG_DATA_W'($urandom_range(150, 400)));
			end else begin
				write_reg(REG_MIN_RATIO, CFG_DATA_W'($urandom_range(0, 1023)));
				write_reg(REG_MAX_RATIO, CFG_DATA_W'($urandom_range(0, 1023)));
			end
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					CFG_DATA_W'($urandom_range(0, 1023)));
		end
		endcase
	endtask

	// Hold the sink off and stream short lines back to back.
	task automatic squeeze();
		hold_request = 1'b1;
		steady = 1'b1;
		repeat (14) begin
			if ($urandom_range(0, 1))
				send_pattern_line(1'b0, 1'b1);
			else
				send_noise_line(4);
		end
		steady = 1'b0;
	endtask

	initial begin : stimulus
		int unsigned random_start;
		int unsigned phase;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// Directed lines under the reset bounds.
		emit_pixel(8'hFF, 1'b1);                       // one-pixel line, white
		emit_pixel(8'h00, 1'b1);                       // one-pixel line, black
		send_runs('{1, 1, 3, 1, 1}, 1'b0);             // exact pattern, passes
		send_runs('{1, 1, 3, 1, 1, 3}, 1'b1);          // later tie must not win
		send_runs('{1, 3, 1, 1}, 1'b0);                // one run before longest
		wait_idle();

		// Sink blocked while the sender keeps pushing.
		squeeze();
		wait_idle();

		random_start = items_sent;
		phase = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			set_bounds(phase);
			if (phase == FIXED_PHASES + 3)
				squeeze();
			repeat ($urandom_range(4, 9)) send_random_line();
			// sender waits for every result before the next bound change
			wait_idle();
			phase++;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[files.f]
src/fprc_pkg.sv
src/fprc_run_tracker.sv
src/fprc_ratio_check.sv
src/finder_pattern_run_ratio_check.sv
src/fprc_checker.sv
bench/fprc_checker.sv
bench/finder_pattern_run_ratio_check_test.sv
